### rtl/bfs_pkg.sv
// ---------------------------------------------------------------------------
// bfs_pkg
// Shared types and constants of the flock step block: register indexes,
// world size, unit-vector request and response words.
// ---------------------------------------------------------------------------
package bfs_pkg;

   // register indexes of the csr port
   localparam logic [2:0] CSR_BIRD_COUNT = 3'd0;
   localparam logic [2:0] CSR_VISUAL     = 3'd1;
   localparam logic [2:0] CSR_SEPARATION = 3'd2;
   localparam logic [2:0] CSR_COHERE     = 3'd3;
   localparam logic [2:0] CSR_SEPARATE   = 3'd4;
   localparam logic [2:0] CSR_ALIGN      = 3'd5;
   localparam logic [2:0] CSR_SPEED      = 3'd6;

   // register reset values
   localparam logic [8:0]  RST_BIRD_COUNT = 9'd256;
   localparam logic [15:0] RST_VISUAL     = 16'd3200;
   localparam logic [15:0] RST_SEPARATION = 16'd1280;
   localparam logic [15:0] RST_COHERE     = 16'd41;
   localparam logic [15:0] RST_SEPARATE   = 16'd205;
   localparam logic [15:0] RST_ALIGN      = 16'd205;
   localparam logic [15:0] RST_SPEED      = 16'd512;

   // world edges in Q10.6 and 1.0 in Q1.14
   localparam logic signed [17:0] WORLD_X  = 18'sd51200;
   localparam logic signed [17:0] WORLD_Y  = 18'sd38400;
   localparam logic [14:0]        UNIT_ONE = 15'd16384;

   // magnitude width on the unit-vector request
   localparam int UNIT_MAG_W = 24;

   typedef struct packed {
      logic                  go;
      logic                  neg_a;
      logic                  neg_b;
      logic [UNIT_MAG_W-1:0] mag_a;
      logic [UNIT_MAG_W-1:0] mag_b;
   } unit_req_type;

   typedef struct packed {
      logic               done;
      logic signed [15:0] ux;
      logic signed [15:0] uy;
   } unit_rsp_type;

endpackage

### rtl/bfs_ram.sv
// ---------------------------------------------------------------------------
// bfs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bfs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bfs_div.sv
// ---------------------------------------------------------------------------
// bfs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bfs_div
   import bfs_pkg::*;
#(
   parameter int NUM_W = 24,
   parameter int DEN_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W+1:0] diff;

   // trial subtract of the shifted remainder
   always_comb begin
      rem_sh = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, den_ff};
   end

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = diff[DEN_W+1] ? rem_sh : diff[DEN_W:0];
         quo_in = {quo_ff[NUM_W-2:0], ~diff[DEN_W+1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

### rtl/bfs_unit.sv
// ---------------------------------------------------------------------------
// bfs_unit
// Unit-vector unit: halves the magnitudes into range, squares and sums,
// takes an integer root two bits a cycle, then divides both components.
// ---------------------------------------------------------------------------
module bfs_unit
   import bfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  unit_req_type req,
   output unit_rsp_type rsp
);

   localparam logic [2:0] U_IDLE = 3'd0;
   localparam logic [2:0] U_HALF = 3'd1;
   localparam logic [2:0] U_MUL  = 3'd2;
   localparam logic [2:0] U_SUM  = 3'd3;
   localparam logic [2:0] U_SQRT = 3'd4;
   localparam logic [2:0] U_DIV  = 3'd5;
   localparam logic [2:0] U_DONE = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic                  neg_a_ff, neg_a_in, neg_b_ff, neg_b_in;
   logic [UNIT_MAG_W-1:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [39:0]           pa_ff, pa_in, pb_ff, pb_in;
   logic [61:0]           rad_ff, rad_in;
   logic [32:0]           rem_ff, rem_in;
   logic [30:0]           root_ff, root_in;
   logic [31:0]           ra_ff, ra_in, rb_ff, rb_in;
   logic [14:0]           qa_ff, qa_in, qb_ff, qb_in;
   logic [40:0]           m2;
   logic [34:0]           rem_sh, trial;
   logic [32:0]           rs_a, rs_b, m_ext;
   logic [14:0]           ca, cb;

   always_comb begin
      m2     = {1'b0, pa_ff} + {1'b0, pb_ff};
      rem_sh = {rem_ff, rad_ff[61:60]};
      trial  = {2'b00, root_ff, 2'b01};
      rs_a   = {ra_ff, 1'b0};
      rs_b   = {rb_ff, 1'b0};
      m_ext  = {2'b00, root_ff};
      ca     = (qa_ff > UNIT_ONE) ? UNIT_ONE : qa_ff;
      cb     = (qb_ff > UNIT_ONE) ? UNIT_ONE : qb_ff;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      neg_a_in = neg_a_ff;
      neg_b_in = neg_b_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      ra_in    = ra_ff;
      rb_in    = rb_ff;
      qa_in    = qa_ff;
      qb_in    = qb_ff;
      case (state_ff)
         U_IDLE: begin
            if (req.go) begin
               neg_a_in = req.neg_a;
               neg_b_in = req.neg_b;
               ma_in    = req.mag_a;
               mb_in    = req.mag_b;
               state_in = U_HALF;
            end
         end
         // halve both until each is below 2^20
         U_HALF: begin
            if ((ma_ff[UNIT_MAG_W-1:20] != '0) || (mb_ff[UNIT_MAG_W-1:20] != '0)) begin
               ma_in = ma_ff >> 1;
               mb_in = mb_ff >> 1;
            end else begin
               state_in = U_MUL;
            end
         end
         U_MUL: begin
            pa_in    = ma_ff[19:0] * ma_ff[19:0];
            pb_in    = mb_ff[19:0] * mb_ff[19:0];
            state_in = U_SUM;
         end
         U_SUM: begin
            if (m2 == '0) begin
               state_in = U_DONE;
            end else begin
               rad_in   = {1'b0, m2, 20'b0};
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = U_SQRT;
            end
         end
         // root, two radicand bits a cycle
         U_SQRT: begin
            if (rem_sh >= trial) begin
               rem_in  = 33'(rem_sh - trial);
               root_in = {root_ff[29:0], 1'b1};
            end else begin
               rem_in  = rem_sh[32:0];
               root_in = {root_ff[29:0], 1'b0};
            end
            rad_in = {rad_ff[59:0], 2'b00};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd30) begin
               ra_in    = {3'b000, ma_ff[19:0], 9'b0};
               rb_in    = {3'b000, mb_ff[19:0], 9'b0};
               qa_in    = '0;
               qb_in    = '0;
               cnt_in   = '0;
               state_in = U_DIV;
            end
         end
         // both component divides side by side, low numerator bits are zero
         U_DIV: begin
            if (rs_a >= m_ext) begin
               ra_in = 32'(rs_a - m_ext);
               qa_in = {qa_ff[13:0], 1'b1};
            end else begin
               ra_in = rs_a[31:0];
               qa_in = {qa_ff[13:0], 1'b0};
            end
            if (rs_b >= m_ext) begin
               rb_in = 32'(rs_b - m_ext);
               qb_in = {qb_ff[13:0], 1'b1};
            end else begin
               rb_in = rs_b[31:0];
               qb_in = {qb_ff[13:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd14) begin
               state_in = U_DONE;
            end
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      neg_a_ff <= neg_a_in;
      neg_b_ff <= neg_b_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      ra_ff    <= ra_in;
      rb_ff    <= rb_in;
      qa_ff    <= qa_in;
      qb_ff    <= qb_in;
   end

   // response, zero vector or capped signed quotients
   always_comb begin
      rsp.done = (state_ff == U_DONE);
      if (m2 == '0) begin
         rsp.ux = '0;
         rsp.uy = '0;
      end else begin
         rsp.ux = neg_a_ff ? -$signed({1'b0, ca}) : $signed({1'b0, ca});
         rsp.uy = neg_b_ff ? -$signed({1'b0, cb}) : $signed({1'b0, cb});
      end
   end

endmodule

### rtl/boids_flock_step_top.sv
// ---------------------------------------------------------------------------
// boids_flock_step_top
// Flock update: a bird table in one RAM, a scan sequencer over it, a shared
// unit-vector unit and a divider for the neighbour averages.
// Load word: written in the accept cycle, busy stays low, no result.
// Step word: reads the own entry, then scans the other birds; each neighbour goes
//   through the unit-vector unit (no root or divide on the same spot). The six
//   averages take one divide each (none with no neighbours), then the gains,
//   the final normalise and move; the unit-vector unit has 31 root steps and 15
//   divide steps. Busy until write back; result strobe in the cycle busy falls.
// Synchronous reset clears control and the configuration registers, not the bird table.
// The result strobe lasts one cycle and cannot be held off.
// ---------------------------------------------------------------------------
module boids_flock_step_top
   import bfs_pkg::*;
#(
   parameter int MAX_BIRDS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic [7:0]         req_bird_index,
   input  logic [15:0]        req_load_x,
   input  logic [15:0]        req_load_y,
   input  logic signed [15:0] req_load_vx,
   input  logic signed [15:0] req_load_vy,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_out_index,
   output logic [15:0]        rsp_new_x,
   output logic [15:0]        rsp_new_y,
   output logic signed [15:0] rsp_new_vx,
   output logic signed [15:0] rsp_new_vy,
   output logic [7:0]         rsp_neighbour_count
);

   localparam int AW  = (MAX_BIRDS > 1) ? $clog2(MAX_BIRDS) : 1;
   localparam int NCW = AW + 1;
   localparam int JW  = (AW + 1 > 9) ? AW + 1 : 9;
   localparam int SW  = AW + 17;

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_SELF_RD   = 5'd1;
   localparam logic [4:0] S_SELF_LAT  = 5'd2;
   localparam logic [4:0] S_SCAN_RD   = 5'd3;
   localparam logic [4:0] S_SCAN_LAT  = 5'd4;
   localparam logic [4:0] S_SCAN_SQ   = 5'd5;
   localparam logic [4:0] S_SCAN_CMP  = 5'd6;
   localparam logic [4:0] S_UNIT_WAIT = 5'd7;
   localparam logic [4:0] S_AVG_GO    = 5'd8;
   localparam logic [4:0] S_AVG_WAIT  = 5'd9;
   localparam logic [4:0] S_SCALE_MUL = 5'd10;
   localparam logic [4:0] S_SCALE_ADD = 5'd11;
   localparam logic [4:0] S_NORM_GO   = 5'd12;
   localparam logic [4:0] S_NORM_WAIT = 5'd13;
   localparam logic [4:0] S_MOVE_MUL  = 5'd14;
   localparam logic [4:0] S_MOVE_OUT  = 5'd15;

   // configuration registers
   logic [8:0]  bird_count_ff;
   logic [15:0] visual_ff, separation_ff, cohere_ff, separate_ff, align_ff, speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bird_count_ff <= RST_BIRD_COUNT;
         visual_ff     <= RST_VISUAL;
         separation_ff <= RST_SEPARATION;
         cohere_ff     <= RST_COHERE;
         separate_ff   <= RST_SEPARATE;
         align_ff      <= RST_ALIGN;
         speed_ff      <= RST_SPEED;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BIRD_COUNT: bird_count_ff <= csr_wdata[8:0];
            CSR_VISUAL:     visual_ff     <= csr_wdata;
            CSR_SEPARATION: separation_ff <= csr_wdata;
            CSR_COHERE:     cohere_ff     <= csr_wdata;
            CSR_SEPARATE:   separate_ff   <= csr_wdata;
            CSR_ALIGN:      align_ff      <= csr_wdata;
            CSR_SPEED:      speed_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   logic [4:0]           state_ff, state_in;
   logic [7:0]           idx_ff, idx_in;
   logic [AW-1:0]        self_ff, self_in;
   logic [JW-1:0]        j_ff, j_in, cnt_ff, cnt_in;
   logic [NCW-1:0]       n_ff, n_in;
   logic [2:0]           k_ff, k_in;
   logic [31:0]          vd2_ff, vd2_in, sd2_ff, sd2_in;
   logic [15:0]          x1_ff, x1_in, y1_ff, y1_in;
   logic [15:0]          mdx_ff, mdx_in, mdy_ff, mdy_in;
   logic                 ndx_ff, ndx_in, ndy_ff, ndy_in, sep_ff, sep_in;
   logic [15:0]          vxj_ff, vxj_in, vyj_ff, vyj_in;
   logic [31:0]          dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic signed [SW-1:0] sum_ff [6];
   logic signed [SW-1:0] sum_in [6];
   logic [15:0]          avg_ff [6];
   logic [15:0]          avg_in [6];
   logic [5:0]           aneg_ff, aneg_in;
   logic [31:0]          prod_ff, prod_in;
   logic signed [23:0]   accx_ff, accx_in, accy_ff, accy_in;
   logic signed [15:0]   nvx_ff, nvx_in, nvy_ff, nvy_in;
   logic [30:0]          mvx_ff, mvx_in, mvy_ff, mvy_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]           rsp_idx_ff, rsp_idx_in, rsp_cnt_ff, rsp_cnt_in;
   logic [15:0]          rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic signed [15:0]   rsp_vx_ff, rsp_vx_in, rsp_vy_ff, rsp_vy_in;

   logic                 accept, idx_ok;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [63:0]          wr_data, rd_data;
   unit_req_type         ureq;
   unit_rsp_type         ursp;
   logic                 div_start, div_done;
   logic [SW-1:0]        div_num, div_quo;
   logic signed [16:0]   dx, dy;
   logic [32:0]          d2;
   logic signed [SW-1:0] ux_e, uy_e;
   logic signed [SW-1:0] sum_k;
   logic [15:0]          gain;
   logic signed [23:0]   term;
   logic signed [17:0]   nx, ny;
   logic [17:0]          nx_w, ny_w;

   assign accept = start && !busy;
   assign idx_ok = (32'(req_bird_index) < MAX_BIRDS);
   assign busy   = (state_ff != S_IDLE);

   // bird table: {vy, vx, y, x}
   bfs_ram #(
      .WIDTH(64),
      .DEPTH(MAX_BIRDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bfs_unit u_unit (
      .clock (clock),
      .reset (reset),
      .req   (ureq),
      .rsp   (ursp)
   );

   bfs_div #(
      .NUM_W(SW),
      .DEN_W(NCW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (n_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // datapath helpers
   always_comb begin
      dx    = $signed({1'b0, rd_data[15:0]}) - $signed({1'b0, x1_ff});
      dy    = $signed({1'b0, rd_data[31:16]}) - $signed({1'b0, y1_ff});
      d2    = {1'b0, dx2_ff} + {1'b0, dy2_ff};
      ux_e  = {{(SW-16){ursp.ux[15]}}, ursp.ux};
      uy_e  = {{(SW-16){ursp.uy[15]}}, ursp.uy};
      sum_k = sum_ff[k_ff];
      case (k_ff[2:1])
         2'd0:    gain = cohere_ff;
         2'd1:    gain = separate_ff;
         default: gain = align_ff;
      endcase
      term = aneg_ff[k_ff] ? -$signed({4'b0, prod_ff[31:12]})
                           : $signed({4'b0, prod_ff[31:12]});
      nx = nvx_ff[15] ? $signed({2'b0, x1_ff}) - $signed({3'b0, mvx_ff[30:16]})
                      : $signed({2'b0, x1_ff}) + $signed({3'b0, mvx_ff[30:16]});
      ny = nvy_ff[15] ? $signed({2'b0, y1_ff}) - $signed({3'b0, mvy_ff[30:16]})
                      : $signed({2'b0, y1_ff}) + $signed({3'b0, mvy_ff[30:16]});
      // wrap at the world edges
      if (nx < 0) begin
         nx_w = WORLD_X;
      end else if (nx > WORLD_X) begin
         nx_w = '0;
      end else begin
         nx_w = nx;
      end
      if (ny < 0) begin
         ny_w = WORLD_Y;
      end else if (ny > WORLD_Y) begin
         ny_w = '0;
      end else begin
         ny_w = ny;
      end
   end

   // memory ports
   always_comb begin
      rd_addr = (state_ff == S_SELF_RD) ? self_ff : j_ff[AW-1:0];
      if (state_ff == S_MOVE_OUT) begin
         wr_en   = 1'b1;
         wr_addr = self_ff;
         wr_data = {nvy_ff, nvx_ff, ny_w[15:0], nx_w[15:0]};
      end else begin
         wr_en   = accept && !req_kind && idx_ok;
         wr_addr = AW'(req_bird_index);
         wr_data = {req_load_vy, req_load_vx, req_load_y, req_load_x};
      end
   end

   // unit and divider requests
   always_comb begin
      ureq.go    = 1'b0;
      ureq.neg_a = ndx_ff;
      ureq.neg_b = ndy_ff;
      ureq.mag_a = {{(UNIT_MAG_W-16){1'b0}}, mdx_ff};
      ureq.mag_b = {{(UNIT_MAG_W-16){1'b0}}, mdy_ff};
      if (state_ff == S_SCAN_CMP) begin
         ureq.go = (d2 < {1'b0, vd2_ff});
      end else if (state_ff == S_NORM_GO) begin
         ureq.go    = 1'b1;
         ureq.neg_a = accx_ff[23];
         ureq.neg_b = accy_ff[23];
         ureq.mag_a = accx_ff[23] ? 24'(-accx_ff) : 24'(accx_ff);
         ureq.mag_b = accy_ff[23] ? 24'(-accy_ff) : 24'(accy_ff);
      end
      div_start = (state_ff == S_AVG_GO) && (n_ff != '0);
      div_num   = sum_k[SW-1] ? SW'(-sum_k) : SW'(sum_k);
   end

   // step sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      self_in       = self_ff;
      j_in          = j_ff;
      cnt_in        = cnt_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      vd2_in        = vd2_ff;
      sd2_in        = sd2_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      mdx_in        = mdx_ff;
      mdy_in        = mdy_ff;
      ndx_in        = ndx_ff;
      ndy_in        = ndy_ff;
      sep_in        = sep_ff;
      vxj_in        = vxj_ff;
      vyj_in        = vyj_ff;
      dx2_in        = dx2_ff;
      dy2_in        = dy2_ff;
      sum_in        = sum_ff;
      avg_in        = avg_ff;
      aneg_in       = aneg_ff;
      prod_in       = prod_ff;
      accx_in       = accx_ff;
      accy_in       = accy_ff;
      nvx_in        = nvx_ff;
      nvy_in        = nvy_ff;
      mvx_in        = mvx_ff;
      mvy_in        = mvy_ff;
      rsp_strobe_in = 1'b0;
      rsp_idx_in    = rsp_idx_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_vx_in     = rsp_vx_ff;
      rsp_vy_in     = rsp_vy_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_kind && idx_ok) begin
               idx_in   = req_bird_index;
               self_in  = AW'(req_bird_index);
               state_in = S_SELF_RD;
            end
         end
         // read own entry, square the radii, clear the sums
         S_SELF_RD: begin
            vd2_in  = visual_ff * visual_ff;
            sd2_in  = separation_ff * separation_ff;
            cnt_in  = (32'(bird_count_ff) < MAX_BIRDS) ? JW'(bird_count_ff)
                                                        : JW'(MAX_BIRDS);
            j_in    = '0;
            n_in    = '0;
            aneg_in = '0;
            for (int i = 0; i < 6; i++) begin
               sum_in[i] = '0;
               avg_in[i] = '0;
            end
            state_in = S_SELF_LAT;
         end
         S_SELF_LAT: begin
            x1_in    = rd_data[15:0];
            y1_in    = rd_data[31:16];
            accx_in  = {{8{rd_data[47]}}, rd_data[47:32]};
            accy_in  = {{8{rd_data[63]}}, rd_data[63:48]};
            state_in = S_SCAN_RD;
         end
         // scan loop over the first bird_count entries, at most MAX_BIRDS, skipping the own entry
         S_SCAN_RD: begin
            if (j_ff >= cnt_ff) begin
               k_in     = '0;
               state_in = S_AVG_GO;
            end else if (j_ff == JW'(idx_ff)) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = S_SCAN_LAT;
            end
         end
         S_SCAN_LAT: begin
            ndx_in   = dx[16];
            ndy_in   = dy[16];
            mdx_in   = dx[16] ? 16'(-dx) : dx[15:0];
            mdy_in   = dy[16] ? 16'(-dy) : dy[15:0];
            vxj_in   = rd_data[47:32];
            vyj_in   = rd_data[63:48];
            state_in = S_SCAN_SQ;
         end
         S_SCAN_SQ: begin
            dx2_in   = mdx_ff * mdx_ff;
            dy2_in   = mdy_ff * mdy_ff;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (d2 < {1'b0, vd2_ff}) begin
               sep_in   = (d2 < {1'b0, sd2_ff});
               state_in = S_UNIT_WAIT;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         // neighbour direction ready, accumulate
         S_UNIT_WAIT: begin
            if (ursp.done) begin
               sum_in[0] = sum_ff[0] + ux_e;
               sum_in[1] = sum_ff[1] + uy_e;
               if (sep_ff) begin
                  sum_in[2] = sum_ff[2] - ux_e;
                  sum_in[3] = sum_ff[3] - uy_e;
               end
               sum_in[4] = sum_ff[4] + {{(SW-16){vxj_ff[15]}}, vxj_ff};
               sum_in[5] = sum_ff[5] + {{(SW-16){vyj_ff[15]}}, vyj_ff};
               n_in      = n_ff + 1'b1;
               j_in      = j_ff + 1'b1;
               state_in  = S_SCAN_RD;
            end
         end
         // averages, one divide per sum, none with no neighbours
         S_AVG_GO: begin
            if (n_ff == '0) begin
               k_in     = '0;
               state_in = S_SCALE_MUL;
            end else begin
               state_in = S_AVG_WAIT;
            end
         end
         S_AVG_WAIT: begin
            if (div_done) begin
               avg_in[k_ff]  = div_quo[15:0];
               aneg_in[k_ff] = sum_k[SW-1];
               if (k_ff == 3'd5) begin
                  k_in     = '0;
                  state_in = S_SCALE_MUL;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_AVG_GO;
               end
            end
         end
         // gain scaling and velocity update
         S_SCALE_MUL: begin
            prod_in  = avg_ff[k_ff] * gain;
            state_in = S_SCALE_ADD;
         end
         S_SCALE_ADD: begin
            if (k_ff[0]) begin
               accy_in = accy_ff + term;
            end else begin
               accx_in = accx_ff + term;
            end
            if (k_ff == 3'd5) begin
               state_in = S_NORM_GO;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_SCALE_MUL;
            end
         end
         S_NORM_GO: begin
            state_in = S_NORM_WAIT;
         end
         S_NORM_WAIT: begin
            if (ursp.done) begin
               nvx_in   = ursp.ux;
               nvy_in   = ursp.uy;
               state_in = S_MOVE_MUL;
            end
         end
         S_MOVE_MUL: begin
            mvx_in   = (nvx_ff[15] ? 15'(-nvx_ff) : nvx_ff[14:0]) * speed_ff;
            mvy_in   = (nvy_ff[15] ? 15'(-nvy_ff) : nvy_ff[14:0]) * speed_ff;
            state_in = S_MOVE_OUT;
         end
         // write back and emit the result word
         S_MOVE_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_idx_in    = idx_ff;
            rsp_x_in      = nx_w[15:0];
            rsp_y_in      = ny_w[15:0];
            rsp_vx_in     = nvx_ff;
            rsp_vy_in     = nvy_ff;
            rsp_cnt_in    = (32'(n_ff) > 32'd255) ? 8'hFF : 8'(n_ff);
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      idx_ff     <= idx_in;
      self_ff    <= self_in;
      j_ff       <= j_in;
      cnt_ff     <= cnt_in;
      n_ff       <= n_in;
      k_ff       <= k_in;
      vd2_ff     <= vd2_in;
      sd2_ff     <= sd2_in;
      x1_ff      <= x1_in;
      y1_ff      <= y1_in;
      mdx_ff     <= mdx_in;
      mdy_ff     <= mdy_in;
      ndx_ff     <= ndx_in;
      ndy_ff     <= ndy_in;
      sep_ff     <= sep_in;
      vxj_ff     <= vxj_in;
      vyj_ff     <= vyj_in;
      dx2_ff     <= dx2_in;
      dy2_ff     <= dy2_in;
      sum_ff     <= sum_in;
      avg_ff     <= avg_in;
      aneg_ff    <= aneg_in;
      prod_ff    <= prod_in;
      accx_ff    <= accx_in;
      accy_ff    <= accy_in;
      nvx_ff     <= nvx_in;
      nvy_ff     <= nvy_in;
      mvx_ff     <= mvx_in;
      mvy_ff     <= mvy_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_vx_ff  <= rsp_vx_in;
      rsp_vy_ff  <= rsp_vy_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_out_index       = rsp_idx_ff;
   assign rsp_new_x           = rsp_x_ff;
   assign rsp_new_y           = rsp_y_ff;
   assign rsp_new_vx          = rsp_vx_ff;
   assign rsp_new_vy          = rsp_vy_ff;
   assign rsp_neighbour_count = rsp_cnt_ff;

endmodule

### sim/tb_boids_flock_step_top.sv
// ---------------------------------------------------------------------------
// tb_boids_flock_step_top
// Self-checking bench for the flock step block. Loads the whole bird table,
// then runs a directed set of loads and steps and several randomized phases
// under different register settings. A fixed-point flock predictor tracks
// the bird table and the registers and checks every step result word.
// ---------------------------------------------------------------------------
module tb_boids_flock_step_top;
   import bfs_pkg::*;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;
   localparam int   NUM_BIRDS = 256;
   localparam int   WATCH_LIMIT = 100000;
   localparam int   SETTLE_CYCLES = 40;

   typedef struct {
      logic              kind;
      logic [7:0]        idx;
      logic [15:0]       x;
      logic [15:0]       y;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
   } bird_cmd_type;

   typedef struct packed {
      logic [7:0]         idx;
      logic [15:0]        x;
      logic [15:0]        y;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic [7:0]         n;
   } flock_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_kind = 1'b0;
   logic [7:0]         req_bird_index = '0;
   logic [15:0]        req_load_x = '0;
   logic [15:0]        req_load_y = '0;
   logic signed [15:0] req_load_vx = '0;
   logic signed [15:0] req_load_vy = '0;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;
   logic               rsp_strobe;
   logic [7:0]         rsp_out_index;
   logic [15:0]        rsp_new_x;
   logic [15:0]        rsp_new_y;
   logic signed [15:0] rsp_new_vx;
   logic signed [15:0] rsp_new_vy;
   logic [7:0]         rsp_neighbour_count;

   // predictor copy of the bird table and registers
   logic [15:0] bird_x [NUM_BIRDS];
   logic [15:0] bird_y [NUM_BIRDS];
   logic [15:0] bird_vx [NUM_BIRDS];
   logic [15:0] bird_vy [NUM_BIRDS];
   logic [8:0]  cfg_count = RST_BIRD_COUNT;
   logic [15:0] cfg_visual = RST_VISUAL;
   logic [15:0] cfg_separation = RST_SEPARATION;
   logic [15:0] cfg_cohere = RST_COHERE;
   logic [15:0] cfg_separate = RST_SEPARATE;
   logic [15:0] cfg_align = RST_ALIGN;
   logic [15:0] cfg_speed = RST_SPEED;

   bird_cmd_type   pending_cmds [$];
   flock_word_type expected_words [$];
   int          sender_idle_pct = 18;
   int          mismatches = 0;
   int          loads_sent = 0;
   int          steps_sent = 0;
   int          words_checked = 0;
   int          quiet_cycles = 0;

   boids_flock_step_top dut (.*);

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // integer square root, floor
   function automatic longint root_floor(input longint v);
      longint res;
      longint bw;
      res = 0;
      bw = longint'(1) << 62;
      while (bw > v) bw = bw >> 2;
      while (bw != 0) begin
         if (v >= res + bw) begin
            v = v - (res + bw);
            res = (res >> 1) + bw;
         end else begin
            res = res >> 1;
         end
         bw = bw >> 2;
      end
      return res;
   endfunction

   // unit direction in Q1.14, zero for a zero-length vector
   function automatic void unit_dir(input longint a, input longint b,
                                    output longint ox, output longint oy);
      longint ma, mb, m2, m, qa, qb;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      while (ma >= (longint'(1) << 20) || mb >= (longint'(1) << 20)) begin
         ma = ma >> 1;
         mb = mb >> 1;
      end
      m2 = ma * ma + mb * mb;
      if (m2 == 0) begin
         ox = 0;
         oy = 0;
         return;
      end
      m = root_floor(m2 << 20);
      qa = (ma << 24) / m;
      qb = (mb << 24) / m;
      if (qa > 16384) qa = 16384;
      if (qb > 16384) qb = 16384;
      ox = (a < 0) ? -qa : qa;
      oy = (b < 0) ? -qb : qb;
   endfunction

   // one flock update of bird idx; writes the bird back
   function automatic flock_word_type advance_bird(input logic [7:0] idx);
      flock_word_type w;
      longint x1, y1, vx, vy, ux, uy, nvx, nvy, nx, ny, dx, dy, d2;
      longint vd2, sd2, cnt, n;
      longint coh_x, coh_y, sep_x, sep_y, mat_x, mat_y;
      x1 = longint'(bird_x[idx]);
      y1 = longint'(bird_y[idx]);
      vx = longint'($signed(bird_vx[idx]));
      vy = longint'($signed(bird_vy[idx]));
      vd2 = longint'(cfg_visual) * longint'(cfg_visual);
      sd2 = longint'(cfg_separation) * longint'(cfg_separation);
      cnt = (cfg_count < NUM_BIRDS) ? longint'(cfg_count) : NUM_BIRDS;
      n = 0;
      coh_x = 0; coh_y = 0; sep_x = 0; sep_y = 0; mat_x = 0; mat_y = 0;
      // neighbour scan
      for (longint j = 0; j < cnt; j++) begin
         if (j == longint'(idx)) continue;
         dx = longint'(bird_x[j]) - x1;
         dy = longint'(bird_y[j]) - y1;
         d2 = dx * dx + dy * dy;
         if (d2 < vd2) begin
            n++;
            unit_dir(dx, dy, ux, uy);
            coh_x += ux;
            coh_y += uy;
            if (d2 < sd2) begin
               sep_x -= ux;
               sep_y -= uy;
            end
            mat_x += longint'($signed(bird_vx[j]));
            mat_y += longint'($signed(bird_vy[j]));
         end
      end
      // averages
      if (n > 0) begin
         coh_x /= n; coh_y /= n;
         sep_x /= n; sep_y /= n;
         mat_x /= n; mat_y /= n;
      end
      vx += (coh_x * longint'(cfg_cohere)) / 4096
          + (sep_x * longint'(cfg_separate)) / 4096
          + (mat_x * longint'(cfg_align)) / 4096;
      vy += (coh_y * longint'(cfg_cohere)) / 4096
          + (sep_y * longint'(cfg_separate)) / 4096
          + (mat_y * longint'(cfg_align)) / 4096;
      unit_dir(vx, vy, nvx, nvy);
      // move and wrap
      nx = x1 + (nvx * longint'(cfg_speed)) / 65536;
      ny = y1 + (nvy * longint'(cfg_speed)) / 65536;
      if (nx < 0) nx = 51200;
      else if (nx > 51200) nx = 0;
      if (ny < 0) ny = 38400;
      else if (ny > 38400) ny = 0;
      bird_x[idx] = nx[15:0];
      bird_y[idx] = ny[15:0];
      bird_vx[idx] = nvx[15:0];
      bird_vy[idx] = nvy[15:0];
      w.idx = idx;
      w.x = nx[15:0];
      w.y = ny[15:0];
      w.vx = nvx[15:0];
      w.vy = nvy[15:0];
      w.n = (n > 255) ? 8'd255 : n[7:0];
      return w;
   endfunction

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("tb: mismatch %s got %0d want %0d", what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input longint got, input longint want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   // driver: accept, predict, then present the next word
   always @(posedge clock) begin
      bird_cmd_type c;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            quiet_cycles = 0;
            if (req_kind == KIND_LOAD) begin
               bird_x[req_bird_index] = req_load_x;
               bird_y[req_bird_index] = req_load_y;
               bird_vx[req_bird_index] = req_load_vx;
               bird_vy[req_bird_index] = req_load_vy;
               loads_sent++;
            end else begin
               expected_words.push_back(advance_bird(req_bird_index));
               steps_sent++;
            end
         end
         if (!start || !busy) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               c = pending_cmds.pop_front();
               start <= 1'b1;
               req_kind <= c.kind;
               req_bird_index <= c.idx;
               req_load_x <= c.x;
               req_load_y <= c.y;
               req_load_vx <= c.vx;
               req_load_vy <= c.vy;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result word with the oldest expectation
   always @(posedge clock) begin
      flock_word_type w;
      if (!reset && rsp_strobe) begin
         quiet_cycles = 0;
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word for bird", rsp_out_index, -1);
         end else begin
            w = expected_words.pop_front();
            check_field("out_index", rsp_out_index, w.idx);
            check_field("new_x", rsp_new_x, w.x);
            check_field("new_y", rsp_new_y, w.y);
            check_field("new_vx", rsp_new_vx, w.vx);
            check_field("new_vy", rsp_new_vy, w.vy);
            check_field("neighbour_count", rsp_neighbour_count, w.n);
            words_checked++;
         end
      end
   end

   // watchdog on cycles without any accepted word or result word
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (quiet_cycles > WATCH_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic push_cmd(input logic kind, input int idx, input int x, input int y,
                           input int vx, input int vy);
      bird_cmd_type c;
      c.kind = kind;
      c.idx = idx[7:0];
      c.x = x[15:0];
      c.y = y[15:0];
      c.vx = vx[15:0];
      c.vy = vy[15:0];
      pending_cmds.push_back(c);
   endtask

   // random words: steps and loads in equal share, indexes mostly in the scanned range, loads mostly clustered
   task automatic add_random(input int items, input int spread);
      int cx, cy, scanned, idx, x, y;
      cx = $urandom_range(51200);
      cy = $urandom_range(38400);
      scanned = (cfg_count == 0) ? NUM_BIRDS : ((cfg_count > NUM_BIRDS) ? NUM_BIRDS : cfg_count);
      for (int k = 0; k < items; k++) begin
         idx = ($urandom_range(9) < 8) ? $urandom_range(scanned - 1) : $urandom_range(255);
         if ($urandom_range(1)) begin
            push_cmd(KIND_STEP, idx, $urandom, $urandom, $urandom, $urandom);
         end else begin
            if ($urandom_range(9) == 0) begin
               x = $urandom_range(51200);
               y = $urandom_range(38400);
            end else begin
               x = cx + $urandom_range(2 * spread) - spread;
               y = cy + $urandom_range(2 * spread) - spread;
               x = (x < 0) ? 0 : ((x > 51200) ? 51200 : x);
               y = (y < 0) ? 0 : ((y > 38400) ? 38400 : y);
            end
            push_cmd(KIND_LOAD, idx, x, y, $urandom_range(32768) - 16384,
                     $urandom_range(32768) - 16384);
         end
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || start || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input int c0, input int c1, input int c2, input int c3,
                             input int c4, input int c5, input int c6);
      int vals [7];
      vals = '{c0, c1, c2, c3, c4, c5, c6};
      for (int i = 0; i < 7; i++) begin
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= vals[i][15:0];
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_count = c0[8:0];
      cfg_visual = c1[15:0];
      cfg_separation = c2[15:0];
      cfg_cohere = c3[15:0];
      cfg_separate = c4[15:0];
      cfg_align = c5[15:0];
      cfg_speed = c6[15:0];
   endtask

   task automatic run_phase(input int c0, input int c1, input int c2, input int c3,
                            input int c4, input int c5, input int c6, input int items,
                            input int spread, input int idle_pct);
      write_regs(c0, c1, c2, c3, c4, c5, c6);
      sender_idle_pct = idle_pct;
      add_random(items, spread);
      drain();
   endtask

   // stimulus sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // fill the whole table so no step reads an unwritten entry
      for (int i = 0; i < NUM_BIRDS; i++)
         push_cmd(KIND_LOAD, i, $urandom_range(51200), $urandom_range(38400),
                  $urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
      // directed: wrap below zero, wrap beyond the far edge
      push_cmd(KIND_LOAD, 0, 0, 0, -16384, -16384);
      push_cmd(KIND_STEP, 0, 0, 0, 0, 0);
      push_cmd(KIND_LOAD, 1, 51200, 38400, 16384, 16384);
      push_cmd(KIND_STEP, 1, 0, 0, 0, 0);
      // two birds at the same spot, both still
      push_cmd(KIND_LOAD, 2, 25600, 19200, 0, 0);
      push_cmd(KIND_LOAD, 3, 25600, 19200, 0, 0);
      push_cmd(KIND_STEP, 2, 0, 0, 0, 0);
      push_cmd(KIND_STEP, 3, 0, 0, 0, 0);
      // loaded beyond the world, extreme velocities
      push_cmd(KIND_LOAD, 4, 65535, 65535, -32768, 32767);
      push_cmd(KIND_STEP, 4, 0, 0, 0, 0);
      push_cmd(KIND_LOAD, 255, 51200, 0, 16384, -16384);
      push_cmd(KIND_STEP, 255, 0, 0, 0, 0);
      push_cmd(KIND_LOAD, 5, 100, 38400, 0, 16384);
      push_cmd(KIND_STEP, 5, 0, 0, 0, 0);
      push_cmd(KIND_STEP, 5, 0, 0, 0, 0);
      add_random(250, 3200);
      drain();
      // register sweeps, extremes included
      run_phase(256, 65535, 65535, 65535, 65535, 65535, 65535, 8, 4000, 18);
      run_phase(1, 0, 0, 0, 0, 0, 0, 100, 1000, 18);
      run_phase(16, 6400, 2560, 4096, 8192, 4096, 1024, 160, 4000, 76);
      run_phase(0, 3200, 1280, 41, 205, 205, 512, 60, 2000, 76);
      run_phase(32, 8000, 3000, $urandom, $urandom, $urandom, $urandom, 160, 6000, 0);
      run_phase(300, 3200, 1280, 41, 205, 205, 512, 40, 3200, 0);
      run_phase(8, 1000, 500, 65535, 0, 65535, 65535, 120, 800, 0);
      write_regs(RST_BIRD_COUNT, RST_VISUAL, RST_SEPARATION, RST_COHERE,
                 RST_SEPARATE, RST_ALIGN, RST_SPEED);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("tb: %0d loads and %0d steps sent, %0d result words checked",
               loads_sent, steps_sent, words_checked);
      $display("tb: eight register settings, %0d mismatches", mismatches);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
